/* rtl/cia_pkg.sv */
// cia_pkg: sizes, codes and item types of the channel id allocator
// used by the channel interfaces, the allocator core and its checker
package cia_pkg;

    localparam int CHANNEL_COUNT = 128;
    localparam int MAP_DEPTH     = 16;
    localparam int REQUEST_DEPTH = 16;

    localparam int CH_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int MI_W   = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int RI_W   = (REQUEST_DEPTH > 1) ? $clog2(REQUEST_DEPTH) : 1;
    localparam int CNT_W  = $clog2(MAP_DEPTH + 1);
    localparam int RCNT_W = $clog2(REQUEST_DEPTH + 1);
    localparam int FC_W   = $clog2(CHANNEL_COUNT + 1);

    localparam logic [7:0] ID_INVALID = 8'hFF;

    // operation codes
    localparam logic [2:0] OP_MARK      = 3'd0;
    localparam logic [2:0] OP_CLR_BITS  = 3'd1;
    localparam logic [2:0] OP_CLR_MAP   = 3'd2;
    localparam logic [2:0] OP_ADD       = 3'd3;
    localparam logic [2:0] OP_REQUIRE   = 3'd4;
    localparam logic [2:0] OP_LOOKUP    = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_ID    = 3'd1;
    localparam logic [2:0] ST_BAD_NUM   = 3'd2;
    localparam logic [2:0] ST_DUP_ID    = 3'd3;
    localparam logic [2:0] ST_NUM_TAKEN = 3'd4;
    localparam logic [2:0] ST_MAP_FULL  = 3'd5;
    localparam logic [2:0] ST_NONE_FREE = 3'd6;
    localparam logic [2:0] ST_NOT_FOUND = 3'd7;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] channel_id;
        logic [7:0] channel_number;
        logic       last;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] assigned_number;
        logic       committed;
        logic [4:0] map_count;
        logic [7:0] free_count;
    } t_res;

endpackage

/* rtl/cia_if.sv */
// cia_in_if / cia_out_if: valid-ready channels carrying request and result items
// depends on cia_pkg
interface cia_in_if;
    import cia_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cia_out_if;
    import cia_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/cia_first_free.sv */
// cia_first_free: priority encoder giving the lowest free channel number
// depends on cia_pkg
module cia_first_free (
    input  logic [cia_pkg::CHANNEL_COUNT-1:0] i_free,
    output logic                              o_found,
    output logic [cia_pkg::CH_W-1:0]          o_index
);
    import cia_pkg::*;

    always_comb begin
        o_index = '0;
        for (int i = CHANNEL_COUNT - 1; i >= 0; i--) begin
            if (i_free[i]) begin
                o_index = CH_W'(i);
            end
        end
        o_found = |i_free;
    end

endmodule

/* rtl/channel_id_allocator_core.sv */
// channel_id_allocator_core: occupied bitmap, id map and require transactions
// depends on cia_pkg, cia_if and cia_first_free
//
// usage
//   i_req carries one request item (operation, channel_id, channel_number, last),
//   o_res one result item per request, in order. both are valid/ready channels.
// pipeline
//   an item is taken into an input register, worked on in one pass of logic and
//   the result lands in an output register. one item per cycle is sustained while
//   the receiver takes results, set by the single pass through the map compares
//   and the 128-bit first-free encoder.
//   state written by one item is seen by the next item.
// reset
//   synchronous, active low. bitmap cleared (all channels free), map and any open
//   transaction emptied, both pipeline registers empty.
// stall
//   while o_res is held the output register keeps its item; the input register
//   keeps one more, then i_req.ready drops until the receiver takes the result.
// transactions
//   require items run against a tentative copy of the map and bitmap. the copy is
//   taken from the committed state on the first require item and committed on the
//   last one only if no item failed. other defined operations discard an open one.
module channel_id_allocator_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cia_in_if.sink    i_req,
    cia_out_if.source o_res
);
    import cia_pkg::*;

    // pipeline registers
    logic r_s1_valid;
    t_req r_s1;
    logic r_out_valid;
    t_res r_out;

    // committed state
    logic [CHANNEL_COUNT-1:0] r_occ;
    logic [FC_W-1:0]          r_free;
    logic [7:0]               r_map_id  [MAP_DEPTH];
    logic [CH_W-1:0]          r_map_num [MAP_DEPTH];
    logic [CNT_W-1:0]         r_map_cnt;

    // tentative state of an open transaction
    logic [7:0]               r_sh_id  [MAP_DEPTH];
    logic [CH_W-1:0]          r_sh_num [MAP_DEPTH];
    logic [CNT_W-1:0]         r_sh_cnt;
    logic [CHANNEL_COUNT-1:0] r_sh_occ;
    logic [7:0]               r_rq_id  [REQUEST_DEPTH];
    logic [RCNT_W-1:0]        r_rq_cnt;
    logic                     r_rq_open;
    logic                     r_rq_failed;

    // next values
    logic [7:0]               n_sh_id  [MAP_DEPTH];
    logic [CH_W-1:0]          n_sh_num [MAP_DEPTH];
    logic [CNT_W-1:0]         n_sh_cnt;
    logic [CHANNEL_COUNT-1:0] n_sh_occ;
    logic [RCNT_W-1:0]        n_rq_cnt;
    logic                     n_rq_open;
    logic                     n_rq_failed;
    logic [CNT_W-1:0]         n_map_cnt;
    logic [FC_W-1:0]          n_free;
    t_res                     n_out;

    // decode and write enables
    logic                     w_adv;
    logic                     w_num_ok;
    logic [CH_W-1:0]          w_num;
    logic                     w_map_hit;
    logic [CH_W-1:0]          w_map_hit_num;
    logic                     w_num_used;
    logic [CHANNEL_COUNT-1:0] w_map_occ;
    logic [CHANNEL_COUNT-1:0] w_e_occ;
    logic [CNT_W-1:0]         w_e_sh_cnt;
    logic [RCNT_W-1:0]        w_e_rq_cnt;
    logic                     w_e_failed;
    logic                     w_rq_dup;
    logic                     w_sh_hit;
    logic [CH_W-1:0]          w_sh_hit_num;
    logic                     w_ff_found;
    logic [CH_W-1:0]          w_ff_index;
    logic                     w_occ_set;
    logic                     w_occ_clr;
    logic                     w_map_add;
    logic                     w_sh_wr;
    logic                     w_sh_add;
    logic                     w_rq_add;
    logic                     w_commit;
    logic [2:0]               w_status;
    logic [CH_W-1:0]          w_anum;
    logic                     w_fail;

    assign w_adv       = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_s1_valid || w_adv;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    assign w_num_ok = {1'b0, r_s1.channel_number} < 9'(CHANNEL_COUNT);
    assign w_num    = r_s1.channel_number[CH_W-1:0];

    // lowest free channel in the tentative bitmap
    cia_first_free u_first_free (
        .i_free  (~w_e_occ),
        .o_found (w_ff_found),
        .o_index (w_ff_index)
    );

    // compares against the committed map and the tentative view
    always_comb begin
        w_map_hit     = 1'b0;
        w_map_hit_num = '0;
        w_num_used    = 1'b0;
        w_map_occ     = '0;
        for (int i = MAP_DEPTH - 1; i >= 0; i--) begin
            if (CNT_W'(i) < r_map_cnt) begin
                w_map_occ[r_map_num[i]] = 1'b1;
                if (r_map_num[i] == w_num) begin
                    w_num_used = 1'b1;
                end
                if (r_map_id[i] == r_s1.channel_id) begin
                    w_map_hit     = 1'b1;
                    w_map_hit_num = r_map_num[i];
                end
            end
        end

        // a transaction that is not open starts from the committed state
        w_e_occ    = r_rq_open ? r_sh_occ : (r_occ | w_map_occ);
        w_e_sh_cnt = r_rq_open ? r_sh_cnt : r_map_cnt;
        w_e_rq_cnt = r_rq_open ? r_rq_cnt : '0;
        w_e_failed = r_rq_open && r_rq_failed;
        for (int i = 0; i < MAP_DEPTH; i++) begin
            n_sh_id[i]  = r_rq_open ? r_sh_id[i]  : r_map_id[i];
            n_sh_num[i] = r_rq_open ? r_sh_num[i] : r_map_num[i];
        end

        w_sh_hit     = 1'b0;
        w_sh_hit_num = '0;
        for (int i = MAP_DEPTH - 1; i >= 0; i--) begin
            if (CNT_W'(i) < w_e_sh_cnt && n_sh_id[i] == r_s1.channel_id) begin
                w_sh_hit     = 1'b1;
                w_sh_hit_num = n_sh_num[i];
            end
        end

        w_rq_dup = 1'b0;
        for (int i = 0; i < REQUEST_DEPTH; i++) begin
            if (RCNT_W'(i) < w_e_rq_cnt && r_rq_id[i] == r_s1.channel_id) begin
                w_rq_dup = 1'b1;
            end
        end
    end

    // item decision
    always_comb begin
        w_status    = ST_OK;
        w_anum      = '0;
        w_occ_set   = 1'b0;
        w_occ_clr   = 1'b0;
        w_map_add   = 1'b0;
        w_sh_wr     = 1'b0;
        w_sh_add    = 1'b0;
        w_rq_add    = 1'b0;
        w_commit    = 1'b0;
        w_fail      = 1'b0;
        n_rq_open   = r_rq_open;
        n_rq_failed = r_rq_failed;
        n_map_cnt   = r_map_cnt;

        case (r_s1.operation)
            OP_MARK: begin
                n_rq_open = 1'b0;
                if (!w_num_ok) begin
                    w_status = ST_BAD_NUM;
                end else begin
                    w_occ_set = 1'b1;
                end
            end
            OP_CLR_BITS: begin
                n_rq_open = 1'b0;
                w_occ_clr = 1'b1;
            end
            OP_CLR_MAP: begin
                n_rq_open = 1'b0;
                n_map_cnt = '0;
            end
            OP_ADD: begin
                n_rq_open = 1'b0;
                if (r_s1.channel_id == ID_INVALID) begin
                    w_status = ST_BAD_ID;
                end else if (!w_num_ok) begin
                    w_status = ST_BAD_NUM;
                end else if (r_map_cnt >= CNT_W'(MAP_DEPTH)) begin
                    w_status = ST_MAP_FULL;
                end else if (w_map_hit) begin
                    w_status = ST_DUP_ID;
                end else if (w_num_used) begin
                    w_status = ST_NUM_TAKEN;
                end else begin
                    w_map_add = 1'b1;
                    n_map_cnt = r_map_cnt + 1'b1;
                end
            end
            OP_REQUIRE: begin
                w_sh_wr = 1'b1;
                if (r_s1.channel_id == ID_INVALID) begin
                    w_status = ST_BAD_ID;
                end else if (w_rq_dup) begin
                    w_status = ST_DUP_ID;
                end else if (w_e_rq_cnt >= RCNT_W'(REQUEST_DEPTH)) begin
                    w_status = ST_MAP_FULL;
                end else begin
                    w_rq_add = 1'b1;
                    if (w_sh_hit) begin
                        w_anum = w_sh_hit_num;
                    end else if (!w_ff_found) begin
                        w_status = ST_NONE_FREE;
                    end else if (w_e_sh_cnt >= CNT_W'(MAP_DEPTH)) begin
                        w_status = ST_MAP_FULL;
                    end else begin
                        w_sh_add = 1'b1;
                        w_anum   = w_ff_index;
                    end
                end
                w_fail      = w_e_failed || (w_status != ST_OK);
                n_rq_failed = w_fail;
                n_rq_open   = !r_s1.last;
                if (r_s1.last && !w_fail) begin
                    w_commit  = 1'b1;
                    // committed count is the tentative count after this item
                    n_map_cnt = w_sh_add ? CNT_W'(w_e_sh_cnt + 1'b1) : w_e_sh_cnt;
                end
            end
            OP_LOOKUP: begin
                n_rq_open = 1'b0;
                if (r_s1.channel_id == ID_INVALID) begin
                    w_status = ST_BAD_ID;
                end else if (!w_map_hit) begin
                    w_status = ST_NOT_FOUND;
                end else begin
                    w_anum = w_map_hit_num;
                end
            end
            default: begin
                // unused codes leave everything as it is
            end
        endcase
    end

    // tentative state, free count and result after this item
    always_comb begin
        n_sh_cnt = w_e_sh_cnt;
        n_sh_occ = w_e_occ;
        n_rq_cnt = w_e_rq_cnt;
        if (w_sh_add) begin
            n_sh_cnt             = w_e_sh_cnt + 1'b1;
            n_sh_occ[w_ff_index] = 1'b1;
        end
        if (w_rq_add) begin
            n_rq_cnt = w_e_rq_cnt + 1'b1;
        end

        n_free = r_free;
        if (w_occ_clr) begin
            n_free = FC_W'(CHANNEL_COUNT);
        end else if (w_occ_set && !r_occ[w_num]) begin
            n_free = r_free - 1'b1;
        end

        n_out.status          = w_status;
        n_out.assigned_number = 7'(w_anum);
        n_out.committed       = w_commit;
        n_out.map_count       = 5'(n_map_cnt);
        n_out.free_count      = 8'(n_free);
    end

    // pipeline and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_occ       <= '0;
            r_free      <= FC_W'(CHANNEL_COUNT);
            r_map_cnt   <= '0;
            r_sh_cnt    <= '0;
            r_sh_occ    <= '0;
            r_rq_cnt    <= '0;
            r_rq_open   <= 1'b0;
            r_rq_failed <= 1'b0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_adv) begin
                r_free      <= n_free;
                r_map_cnt   <= n_map_cnt;
                r_rq_open   <= n_rq_open;
                r_rq_failed <= n_rq_failed;
                if (w_occ_clr) begin
                    r_occ <= '0;
                end else if (w_occ_set) begin
                    r_occ[w_num] <= 1'b1;
                end
                if (w_sh_wr) begin
                    r_sh_cnt <= n_sh_cnt;
                    r_sh_occ <= n_sh_occ;
                    r_rq_cnt <= n_rq_cnt;
                end
            end
        end
    end

    // payload registers and tables
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_s1 <= i_req.data;
        end
        if (w_adv) begin
            r_out <= n_out;
            if (w_map_add) begin
                r_map_id[r_map_cnt[MI_W-1:0]]  <= r_s1.channel_id;
                r_map_num[r_map_cnt[MI_W-1:0]] <= w_num;
            end
            if (w_sh_wr) begin
                for (int i = 0; i < MAP_DEPTH; i++) begin
                    r_sh_id[i]  <= n_sh_id[i];
                    r_sh_num[i] <= n_sh_num[i];
                end
                if (w_sh_add) begin
                    r_sh_id[w_e_sh_cnt[MI_W-1:0]]  <= r_s1.channel_id;
                    r_sh_num[w_e_sh_cnt[MI_W-1:0]] <= w_ff_index;
                end
            end
            if (w_rq_add) begin
                r_rq_id[w_e_rq_cnt[RI_W-1:0]] <= r_s1.channel_id;
            end
            if (w_commit) begin
                for (int i = 0; i < MAP_DEPTH; i++) begin
                    r_map_id[i]  <= n_sh_id[i];
                    r_map_num[i] <= n_sh_num[i];
                end
                if (w_sh_add) begin
                    r_map_id[w_e_sh_cnt[MI_W-1:0]]  <= r_s1.channel_id;
                    r_map_num[w_e_sh_cnt[MI_W-1:0]] <= w_ff_index;
                end
            end
        end
    end

endmodule

/* rtl/cia_chk.sv */
// cia_chk: port-level checks of the channel id allocator, bound to the top level
// depends on cia_pkg and channel_id_allocator_core
module cia_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input cia_pkg::t_res i_out_data
);
    import cia_pkg::*;

    // a held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // a commit only comes with a good status
    a_commit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.committed |-> i_out_data.status == ST_OK)
        else $error("commit with error status");

    // a failed item gives no number
    a_fail_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status != ST_OK |-> i_out_data.assigned_number == '0)
        else $error("number on failed item");

    // the map never holds more than its depth
    a_map_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.map_count <= 5'(MAP_DEPTH))
        else $error("map count overflow");

endmodule

bind channel_id_allocator_core cia_chk u_cia_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

/* sim/testbench.sv */
// testbench: checks channel_id_allocator_core against an in-bench predictor of the
// bitmap, the id map and require transactions; depends on cia_pkg, cia_if and the rtl
module testbench;
    import cia_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cia_in_if  req_if ();
    cia_out_if res_if ();

    channel_id_allocator_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic        occ [CHANNEL_COUNT];
    logic [7:0]  m_id [MAP_DEPTH];
    logic [6:0]  m_num [MAP_DEPTH];
    int          m_cnt;
    logic [7:0]  s_id [MAP_DEPTH];
    logic [6:0]  s_num [MAP_DEPTH];
    int          s_cnt;
    logic        s_occ [CHANNEL_COUNT];
    logic [7:0]  r_id [REQUEST_DEPTH];
    int          r_cnt;
    bit          tr_open;
    bit          tr_failed;

    t_res expected_q[$];
    int   errors = 0;
    int   send_idle = 0;
    int   recv_idle = 0;
    bit   hold_off = 1'b0;

    function automatic logic [2:0] require_one(logic [7:0] id, output logic [6:0] num);
        int i;
        int f;
        num = '0;
        if (id == ID_INVALID) return ST_BAD_ID;
        for (i = 0; i < r_cnt; i++) if (r_id[i] == id) return ST_DUP_ID;
        if (r_cnt >= REQUEST_DEPTH) return ST_MAP_FULL;
        r_id[r_cnt] = id;
        r_cnt++;
        for (i = 0; i < s_cnt; i++) if (s_id[i] == id) begin
            num = s_num[i];
            return ST_OK;
        end
        f = CHANNEL_COUNT;
        for (i = CHANNEL_COUNT - 1; i >= 0; i--) if (!s_occ[i]) f = i;
        if (f >= CHANNEL_COUNT) return ST_NONE_FREE;
        if (s_cnt >= MAP_DEPTH) return ST_MAP_FULL;
        s_id[s_cnt] = id;
        s_num[s_cnt] = f[6:0];
        s_cnt++;
        s_occ[f] = 1'b1;
        num = f[6:0];
        return ST_OK;
    endfunction

    function automatic t_res allocate_predict(t_req r);
        t_res o;
        int i;
        int fc;
        logic [6:0] n;
        o = '0;
        n = '0;
        if (r.operation <= OP_ADD || r.operation == OP_LOOKUP) tr_open = 1'b0;
        case (r.operation)
            OP_MARK: begin
                if (r.channel_number >= CHANNEL_COUNT) o.status = ST_BAD_NUM;
                else occ[r.channel_number] = 1'b1;
            end
            OP_CLR_BITS: for (i = 0; i < CHANNEL_COUNT; i++) occ[i] = 1'b0;
            OP_CLR_MAP: m_cnt = 0;
            OP_ADD: begin
                if (r.channel_id == ID_INVALID) o.status = ST_BAD_ID;
                else if (r.channel_number >= CHANNEL_COUNT) o.status = ST_BAD_NUM;
                else if (m_cnt >= MAP_DEPTH) o.status = ST_MAP_FULL;
                else begin
                    for (i = 0; i < m_cnt; i++)
                        if (o.status == ST_OK && m_id[i] == r.channel_id)
                            o.status = ST_DUP_ID;
                    for (i = 0; i < m_cnt; i++)
                        if (o.status == ST_OK && m_num[i] == r.channel_number[6:0])
                            o.status = ST_NUM_TAKEN;
                    if (o.status == ST_OK) begin
                        m_id[m_cnt] = r.channel_id;
                        m_num[m_cnt] = r.channel_number[6:0];
                        m_cnt++;
                    end
                end
            end
            OP_REQUIRE: begin
                if (!tr_open) begin
                    s_id = m_id;
                    s_num = m_num;
                    s_cnt = m_cnt;
                    s_occ = occ;
                    for (i = 0; i < m_cnt; i++) s_occ[m_num[i]] = 1'b1;
                    r_cnt = 0;
                    tr_failed = 1'b0;
                    tr_open = 1'b1;
                end
                o.status = require_one(r.channel_id, n);
                if (o.status != ST_OK) begin
                    tr_failed = 1'b1;
                    n = '0;
                end
                o.assigned_number = n;
                if (r.last) begin
                    if (!tr_failed) begin
                        m_id = s_id;
                        m_num = s_num;
                        m_cnt = s_cnt;
                        o.committed = 1'b1;
                    end
                    tr_open = 1'b0;
                end
            end
            OP_LOOKUP: begin
                if (r.channel_id == ID_INVALID) o.status = ST_BAD_ID;
                else begin
                    o.status = ST_NOT_FOUND;
                    for (i = 0; i < m_cnt; i++)
                        if (o.status == ST_NOT_FOUND && m_id[i] == r.channel_id) begin
                            o.status = ST_OK;
                            o.assigned_number = m_num[i];
                        end
                end
            end
            default: ;
        endcase
        fc = 0;
        for (i = 0; i < CHANNEL_COUNT; i++) if (!occ[i]) fc++;
        o.map_count = m_cnt[4:0];
        o.free_count = fc[7:0];
        return o;
    endfunction

    // send one item, predicting its result at acceptance; valid stays up
    // until the next item or an idle cycle replaces it
    task automatic send_item(t_req r);
        while ($urandom_range(99) < send_idle) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        expected_q.push_back(allocate_predict(r));
        @(negedge i_clk);
    endtask

    task automatic drain;
        req_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic t_req mk(logic [2:0] op, logic [7:0] id, logic [7:0] num, logic lst);
        t_req r;
        r.operation = op;
        r.channel_id = id;
        r.channel_number = num;
        r.last = lst;
        return r;
    endfunction

    // random item: mostly well-formed require transactions with small id pool
    task automatic random_burst(int n);
        int k;
        int j;
        int len;
        int pick;
        for (k = 0; k < n; ) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                len = $urandom_range(1, 6);
                if ($urandom_range(19) == 0) len = $urandom_range(15, 18);
                for (j = 0; j < len; j++) begin
                    send_item(mk(OP_REQUIRE,
                        ($urandom_range(29) == 0) ? ID_INVALID : 8'($urandom_range(40)),
                        8'($urandom), j == len - 1));
                    k++;
                end
            end else if (pick < 65) begin
                send_item(mk(OP_ADD, ($urandom_range(19) == 0) ? ID_INVALID :
                    8'($urandom_range(40)), ($urandom_range(9) == 0) ? 8'($urandom) :
                    8'($urandom_range(20)), 1'($urandom)));
                k++;
            end else if (pick < 80) begin
                send_item(mk(OP_LOOKUP, ($urandom_range(19) == 0) ? 8'($urandom) :
                    8'($urandom_range(40)), 8'($urandom), 1'($urandom)));
                k++;
            end else if (pick < 90) begin
                send_item(mk(OP_MARK, 8'($urandom), ($urandom_range(4) == 0) ?
                    8'($urandom) : 8'($urandom_range(24)), 1'($urandom)));
                k++;
            end else begin
                // clears are rare so the map and bitmap get to fill
                pick = $urandom_range(9);
                send_item(mk(pick < 2 ? OP_CLR_BITS : pick < 4 ? OP_CLR_MAP :
                    3'($urandom_range(7)), 8'($urandom), 8'($urandom), 1'($urandom)));
                k++;
            end
        end
    endtask

    // result checking at the rising edge
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_q.size() == 0) begin
                $error("result with no expectation: %p", res_if.data);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (res_if.data.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, res_if.data.status);
                    errors++;
                end
                if (res_if.data.assigned_number !== e.assigned_number) begin
                    $error("assigned_number exp %0d got %0d", e.assigned_number,
                        res_if.data.assigned_number);
                    errors++;
                end
                if (res_if.data.committed !== e.committed) begin
                    $error("committed exp %0d got %0d", e.committed, res_if.data.committed);
                    errors++;
                end
                if (res_if.data.map_count !== e.map_count) begin
                    $error("map_count exp %0d got %0d", e.map_count, res_if.data.map_count);
                    errors++;
                end
                if (res_if.data.free_count !== e.free_count) begin
                    $error("free_count exp %0d got %0d", e.free_count,
                        res_if.data.free_count);
                    errors++;
                end
            end
        end
    end

    // receiver ready at the falling edge
    always @(negedge i_clk) begin
        res_if.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end

    typedef struct {
        t_req req;
        bit   known;
        t_res res;
    } t_row;

    t_row rows[$];

    task automatic add_row(t_req r, bit known, logic [2:0] st, logic [6:0] an,
                           logic cm, logic [4:0] mc, logic [7:0] fc);
        t_row w;
        w.req = r;
        w.known = known;
        w.res = '{status: st, assigned_number: an, committed: cm, map_count: mc,
                  free_count: fc};
        rows.push_back(w);
    endtask

    initial begin
        t_res p;
        int i;
        req_if.valid = 1'b0;
        req_if.data = '0;
        res_if.ready = 1'b0;
        for (i = 0; i < CHANNEL_COUNT; i++) begin
            occ[i] = 1'b0;
            s_occ[i] = 1'b0;
        end
        m_cnt = 0;
        s_cnt = 0;
        r_cnt = 0;
        tr_open = 1'b0;
        tr_failed = 1'b0;

        // directed table
        add_row(mk(OP_LOOKUP, 8'd5, 8'd0, 1'b0), 1, ST_NOT_FOUND, 0, 0, 0, 8'd128);
        add_row(mk(OP_LOOKUP, ID_INVALID, 8'd0, 1'b0), 1, ST_BAD_ID, 0, 0, 0, 8'd128);
        add_row(mk(OP_MARK, 8'd0, 8'd0, 1'b0), 1, ST_OK, 0, 0, 0, 8'd127);
        add_row(mk(OP_MARK, 8'd0, 8'd127, 1'b1), 1, ST_OK, 0, 0, 0, 8'd126);
        add_row(mk(OP_MARK, 8'd0, 8'd128, 1'b0), 1, ST_BAD_NUM, 0, 0, 0, 8'd126);
        add_row(mk(OP_MARK, 8'hFF, 8'd255, 1'b0), 1, ST_BAD_NUM, 0, 0, 0, 8'd126);
        add_row(mk(OP_ADD, ID_INVALID, 8'd1, 1'b0), 1, ST_BAD_ID, 0, 0, 0, 8'd126);
        add_row(mk(OP_ADD, 8'd0, 8'd200, 1'b0), 1, ST_BAD_NUM, 0, 0, 0, 8'd126);
        add_row(mk(OP_ADD, 8'd0, 8'd1, 1'b0), 1, ST_OK, 0, 0, 1, 8'd126);
        add_row(mk(OP_ADD, 8'd0, 8'd2, 1'b0), 1, ST_DUP_ID, 0, 0, 1, 8'd126);
        add_row(mk(OP_ADD, 8'd254, 8'd1, 1'b0), 1, ST_NUM_TAKEN, 0, 0, 1, 8'd126);
        add_row(mk(OP_LOOKUP, 8'd0, 8'd0, 1'b0), 1, ST_OK, 1, 0, 1, 8'd126);
        // transaction: mapped id served, new ids take lowest free numbers, a repeated id fails it
        add_row(mk(OP_REQUIRE, 8'd0, 8'd0, 1'b0), 0, 0, 0, 0, 0, 0);
        add_row(mk(OP_REQUIRE, 8'd254, 8'd0, 1'b0), 0, 0, 0, 0, 0, 0);
        add_row(mk(OP_REQUIRE, 8'd254, 8'd0, 1'b0), 0, 0, 0, 0, 0, 0);
        add_row(mk(OP_REQUIRE, 8'd7, 8'd0, 1'b1), 0, 0, 0, 0, 0, 0);
        // committed transaction, one interrupted by a lookup, a failed one and unused codes
        add_row(mk(OP_REQUIRE, 8'd9, 8'hFF, 1'b0), 0, 0, 0, 0, 0, 0);
        add_row(mk(OP_REQUIRE, 8'd10, 8'd0, 1'b1), 0, 0, 0, 0, 0, 0);
        add_row(mk(OP_REQUIRE, 8'd11, 8'd0, 1'b0), 0, 0, 0, 0, 0, 0);
        add_row(mk(OP_LOOKUP, 8'd11, 8'd0, 1'b0), 0, 0, 0, 0, 0, 0);
        add_row(mk(OP_REQUIRE, ID_INVALID, 8'd0, 1'b1), 0, 0, 0, 0, 0, 0);
        add_row(mk(3'd6, 8'd1, 8'd1, 1'b1), 0, 0, 0, 0, 0, 0);
        add_row(mk(3'd7, 8'd1, 8'd1, 1'b0), 0, 0, 0, 0, 0, 0);
        add_row(mk(OP_CLR_MAP, 8'd0, 8'd0, 1'b0), 1, ST_OK, 0, 0, 0, 8'd126);
        add_row(mk(OP_CLR_BITS, 8'd0, 8'd0, 1'b0), 1, ST_OK, 0, 0, 0, 8'd128);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        send_idle = 0;
        recv_idle = 0;
        foreach (rows[k]) begin
            send_item(rows[k].req);
            if (rows[k].known && expected_q[$] !== rows[k].res) begin
                p = expected_q[$];
                $error("directed row %0d predictor %p table %p", k, p, rows[k].res);
                errors++;
            end
        end
        drain();

        // fill every channel so none free shows up, then free again
        for (i = 0; i < CHANNEL_COUNT; i++)
            send_item(mk(OP_MARK, 8'd0, 8'(i), 1'b0));
        send_item(mk(OP_REQUIRE, 8'd3, 8'd0, 1'b1));
        send_item(mk(OP_CLR_BITS, 8'd0, 8'd0, 1'b0));
        // fill the map to the top, then overflow add and require
        for (i = 0; i < MAP_DEPTH + 1; i++)
            send_item(mk(OP_ADD, 8'(i + 100), 8'(i + 50), 1'b0));
        send_item(mk(OP_REQUIRE, 8'd3, 8'd0, 1'b1));
        send_item(mk(OP_CLR_MAP, 8'd0, 8'd0, 1'b0));
        // every input bit toggles
        send_item(mk(OP_LOOKUP, 8'h00, 8'h00, 1'b0));
        send_item(mk(3'd7, 8'hFF, 8'hFF, 1'b1));

        // pressure: long receiver hold-off while items keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (60) @(negedge i_clk);
                hold_off = 1'b0;
            end
            random_burst(12);
        join
        // sender pauses until everything has come back
        drain();

        send_idle = 15;
        recv_idle = 88;
        random_burst(420);
        send_idle = 88;
        recv_idle = 15;
        random_burst(420);
        drain();
        send_idle = 0;
        recv_idle = 0;
        random_burst(420);

        drain();
        repeat (10) @(negedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("channel_id_allocator_core: match");
        end else begin
            $display("channel_id_allocator_core: mismatch");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("channel_id_allocator_core: mismatch");
        $finish;
    end

endmodule
